// ----- hw/rtl/esv_pkg.sv -----
package esv_pkg;

    localparam int W     = 32;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [0:0] {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic           start;
        t_alu_op        op;
        logic [W-1:0]   a;
        logic [W-1:0]   b;
        logic [W-1:0]   m;
    } t_alu_req;

    typedef struct packed {
        logic           done;
        logic [W-1:0]   res;
        logic [W-1:0]   quo;
    } t_alu_rsp;

    localparam logic [0:0] OP_SIGN   = 1'b0;
    localparam logic [0:0] OP_VERIFY = 1'b1;

    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_GENERATOR   = 2'd1;
    localparam logic [1:0] REG_PUBLIC_KEY  = 2'd2;
    localparam logic [1:0] REG_PRIVATE_KEY = 2'd3;

endpackage

// ----- hw/rtl/elgamal_sign_verify_engine_unit.sv -----
// channel   dir   handshake              payload
// request   in    i_valid / o_stall      i_op, i_hash_value, i_nonce, i_check_first,
//                                        i_check_second
// result    out   o_valid / i_stall      o_sign_first, o_sign_second, o_valid_res,
//                                        o_nonce_bad
// config    in    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request at a time; each multiply, reduction or division runs
// on the bit-serial unit in esv_alu; a modexp is one base reduction, then
// a square per exponent bit plus a multiply per set bit; sign adds euclid rounds;
// a refused nonce is reported from the check state or once euclid ends
// reset (synchronous, active low) loads the register defaults and idles
// result held in o_* until taken; o_stall high from accept until it leaves
module elgamal_sign_verify_engine_unit
    import esv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [0:0]   i_op,
    input  logic [W-1:0] i_hash_value,
    input  logic [W-1:0] i_nonce,
    input  logic [W-1:0] i_check_first,
    input  logic [W-1:0] i_check_second,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [W-1:0] o_sign_first,
    output logic [W-1:0] o_sign_second,
    output logic         o_valid_res,
    output logic         o_nonce_bad,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [W-1:0] i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_CHECK    = 11'b00000000010,
        S_EU_TEST  = 11'b00000000100,
        S_EU_DIV   = 11'b00000001000,
        S_EU_MUL   = 11'b00000010000,
        S_POW_BASE = 11'b00000100000,
        S_POW_STEP = 11'b00001000000,
        S_POW_MUL  = 11'b00010000000,
        S_POW_SQR  = 11'b00100000000,
        S_RED      = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } t_state;

    // which modexp is running, selects where it returns
    typedef enum logic [1:0] {
        POW_S1  = 2'd0,
        POW_V1  = 2'd1,
        POW_V2A = 2'd2,
        POW_V2B = 2'd3
    } t_pow_sel;

    // steps of the sign tail, the last verify mult uses the last code
    typedef enum logic [2:0] {
        RED_HM  = 3'd0,
        RED_DM  = 3'd1,
        RED_S1  = 3'd2,
        RED_T   = 3'd3,
        RED_S2  = 3'd4,
        RED_FIN = 3'd5
    } t_red_step;

    localparam logic [W-1:0] ONE = W'(1);

    t_state       r_state;
    t_pow_sel     r_pow_sel;
    t_red_step    r_red;
    logic         r_issued;

    // configuration registers
    logic [W-1:0] r_cfg_p;
    logic [W-1:0] r_cfg_g;
    logic [W-1:0] r_cfg_e2;
    logic [W-1:0] r_cfg_d;

    // request fields
    logic [0:0]   r_op;
    logic [W-1:0] r_h;
    logic [W-1:0] r_r;
    logic [W-1:0] r_c1;
    logic [W-1:0] r_c2;

    // working registers
    logic [W-1:0] r_n;
    logic [W-1:0] r_r0;
    logic [W-1:0] r_r1;
    logic [W-1:0] r_c0;
    logic [W-1:0] r_cc1;
    logic [W-1:0] r_q;
    logic [W-1:0] r_rt;
    logic [W-1:0] r_pbase;
    logic [W-1:0] r_pexp;
    logic [W-1:0] r_pb;
    logic [W-1:0] r_pacc;
    logic [W-1:0] r_s1;
    logic [W-1:0] r_v1;
    logic [W-1:0] r_v2a;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;
    logic [W-1:0] r_tmp;

    // result register
    logic [W-1:0] r_o_first;
    logic [W-1:0] r_o_second;
    logic         r_o_valid_res;
    logic         r_o_bad;

    t_alu_req     alu_req;
    t_alu_rsp     alu_rsp;
    logic         uses_alu;
    logic [W-1:0] n_sub;
    logic [W:0]   sub_wide;

    esv_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // operand select for the shared unit
    always_comb begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ONE;
        alu_req.b  = '0;
        alu_req.m  = r_n;
        uses_alu   = 1'b1;
        unique case (r_state)
            S_EU_DIV: begin
                alu_req.op = ALU_DIV;
                alu_req.b  = r_r0;
                alu_req.m  = r_r1;
            end
            S_EU_MUL: begin
                alu_req.a = r_cc1;
                alu_req.b = r_q;
            end
            S_POW_BASE: begin
                alu_req.b = r_pbase;
                alu_req.m = r_cfg_p;
            end
            S_POW_MUL: begin
                alu_req.a = r_pacc;
                alu_req.b = r_pb;
                alu_req.m = r_cfg_p;
            end
            S_POW_SQR: begin
                alu_req.a = r_pb;
                alu_req.b = r_pb;
                alu_req.m = r_cfg_p;
            end
            S_RED: begin
                case (r_red)
                    RED_HM:  alu_req.b = r_h;
                    RED_DM:  alu_req.b = r_cfg_d;
                    RED_S1:  alu_req.b = r_s1;
                    RED_T: begin
                        alu_req.a = r_y;
                        alu_req.b = r_tmp;
                    end
                    RED_S2: begin
                        alu_req.a = r_tmp;
                        alu_req.b = r_c0;
                    end
                    default: begin
                        alu_req.a = r_v2a;
                        alu_req.b = r_pacc;
                        alu_req.m = r_cfg_p;
                    end
                endcase
            end
            default: uses_alu = 1'b0;
        endcase
        alu_req.start = uses_alu && !r_issued;
    end

    // (minuend - product) mod n, both operands below n
    always_comb begin
        logic [W-1:0] minuend;
        minuend = (r_state == S_EU_MUL) ? r_c0 : r_x;
        if (minuend >= alu_rsp.res) begin
            sub_wide = {1'b0, minuend} - {1'b0, alu_rsp.res};
        end else begin
            sub_wide = {1'b0, minuend} + {1'b0, r_n} - {1'b0, alu_rsp.res};
        end
        n_sub = sub_wide[W-1:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_p  <= W'(3);
            r_cfg_g  <= W'(2);
            r_cfg_e2 <= W'(1);
            r_cfg_d  <= W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODULUS:     r_cfg_p  <= i_cfg_data;
                REG_GENERATOR:   r_cfg_g  <= i_cfg_data;
                REG_PUBLIC_KEY:  r_cfg_e2 <= i_cfg_data;
                REG_PRIVATE_KEY: r_cfg_d  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issued  <= 1'b0;
            r_pow_sel <= POW_S1;
            r_red     <= RED_HM;
        end else begin
            if (alu_req.start) begin
                r_issued <= 1'b1;
            end
            if (alu_rsp.done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cfg_p < W'(3)) begin
                        r_state <= S_DONE;
                    end else if (r_op == OP_SIGN) begin
                        if ((r_r == '0) || (r_r >= r_cfg_p - ONE)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_EU_TEST;
                        end
                    end else begin
                        r_pow_sel <= POW_V1;
                        r_state   <= S_POW_BASE;
                    end
                end
                S_EU_TEST: begin
                    if (r_r1 == '0) begin
                        if (r_r0 != ONE) begin
                            // nonce shares a factor with p-1
                            r_state <= S_DONE;
                        end else begin
                            r_pow_sel <= POW_S1;
                            r_state   <= S_POW_BASE;
                        end
                    end else begin
                        r_state <= S_EU_DIV;
                    end
                end
                S_EU_DIV: begin
                    if (alu_rsp.done) begin
                        r_state <= S_EU_MUL;
                    end
                end
                S_EU_MUL: begin
                    if (alu_rsp.done) begin
                        r_state <= S_EU_TEST;
                    end
                end
                S_POW_BASE: begin
                    if (alu_rsp.done) begin
                        r_state <= S_POW_STEP;
                    end
                end
                S_POW_STEP: begin
                    if (r_pexp == '0) begin
                        unique case (r_pow_sel)
                            POW_S1: begin
                                r_red   <= RED_HM;
                                r_state <= S_RED;
                            end
                            POW_V1: begin
                                r_pow_sel <= POW_V2A;
                                r_state   <= S_POW_BASE;
                            end
                            POW_V2A: begin
                                r_pow_sel <= POW_V2B;
                                r_state   <= S_POW_BASE;
                            end
                            default: begin
                                r_red   <= RED_FIN;
                                r_state <= S_RED;
                            end
                        endcase
                    end else if (r_pexp[0]) begin
                        r_state <= S_POW_MUL;
                    end else begin
                        r_state <= S_POW_SQR;
                    end
                end
                S_POW_MUL: begin
                    if (alu_rsp.done) begin
                        r_state <= S_POW_SQR;
                    end
                end
                S_POW_SQR: begin
                    if (alu_rsp.done) begin
                        r_state <= S_POW_STEP;
                    end
                end
                S_RED: begin
                    if (alu_rsp.done) begin
                        case (r_red)
                            RED_HM:  r_red <= RED_DM;
                            RED_DM:  r_red <= RED_S1;
                            RED_S1:  r_red <= RED_T;
                            RED_T:   r_red <= RED_S2;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_op          <= i_op;
                    r_h           <= i_hash_value;
                    r_r           <= i_nonce;
                    r_c1          <= i_check_first;
                    r_c2          <= i_check_second;
                    r_o_first     <= '0;
                    r_o_second    <= '0;
                    r_o_valid_res <= 1'b0;
                end
            end
            S_CHECK: begin
                r_n   <= r_cfg_p - ONE;
                r_r0  <= r_cfg_p - ONE;
                r_r1  <= r_r;
                r_c0  <= '0;
                r_cc1 <= ONE;
                // first modexp of a verify is g^h
                r_pbase <= r_cfg_g;
                r_pexp  <= r_h;
            end
            S_EU_TEST: begin
                r_pbase <= r_cfg_g;
                r_pexp  <= r_r;
            end
            S_EU_DIV: begin
                if (alu_rsp.done) begin
                    r_q  <= alu_rsp.quo;
                    r_rt <= alu_rsp.res;
                end
            end
            S_EU_MUL: begin
                if (alu_rsp.done) begin
                    r_r0  <= r_r1;
                    r_r1  <= r_rt;
                    r_c0  <= r_cc1;
                    r_cc1 <= n_sub;
                end
            end
            S_POW_BASE: begin
                if (alu_rsp.done) begin
                    r_pb   <= alu_rsp.res;
                    r_pacc <= ONE;
                end
            end
            S_POW_STEP: begin
                if (r_pexp == '0) begin
                    unique case (r_pow_sel)
                        POW_S1: r_s1 <= r_pacc;
                        POW_V1: begin
                            r_v1    <= r_pacc;
                            r_pbase <= r_cfg_e2;
                            r_pexp  <= r_c1;
                        end
                        POW_V2A: begin
                            r_v2a   <= r_pacc;
                            r_pbase <= r_c1;
                            r_pexp  <= r_c2;
                        end
                        default: ;
                    endcase
                end
            end
            S_POW_MUL: begin
                if (alu_rsp.done) begin
                    r_pacc <= alu_rsp.res;
                end
            end
            S_POW_SQR: begin
                if (alu_rsp.done) begin
                    r_pb   <= alu_rsp.res;
                    r_pexp <= {1'b0, r_pexp[W-1:1]};
                end
            end
            S_RED: begin
                if (alu_rsp.done) begin
                    case (r_red)
                        RED_HM:  r_x   <= alu_rsp.res;
                        RED_DM:  r_y   <= alu_rsp.res;
                        RED_S1:  r_tmp <= alu_rsp.res;
                        RED_T:   r_tmp <= n_sub;
                        RED_S2: begin
                            r_o_first  <= r_s1;
                            r_o_second <= alu_rsp.res;
                        end
                        default: r_o_valid_res <= (alu_rsp.res == r_v1);
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_o_bad <= 1'b0;
        end else if (r_state == S_CHECK && r_cfg_p < W'(3)) begin
            r_o_bad <= (r_op == OP_SIGN);
        end else if (r_state == S_CHECK && r_op == OP_SIGN
                     && ((r_r == '0) || (r_r >= r_cfg_p - ONE))) begin
            r_o_bad <= 1'b1;
        end else if (r_state == S_EU_TEST && r_r1 == '0 && r_r0 != ONE) begin
            r_o_bad <= 1'b1;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_sign_first  = r_o_first;
    assign o_sign_second = r_o_second;
    assign o_valid_res   = r_o_valid_res;
    assign o_nonce_bad   = r_o_bad;
    assign o_cfg_ready   = 1'b1;

endmodule

// ----- hw/rtl/esv_alu.sv -----
// bit-serial shared unit: a*b mod m (a < m) or b / m, one bit of b per cycle
module esv_alu
    import esv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [W+1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_m;
    logic [W-1:0]     r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;

    logic             step_bit;
    logic [W+1:0]     t0;
    logic [W+1:0]     t1;
    logic [W+1:0]     n_acc;
    logic             ge1;
    logic             ge2;

    always_comb begin
        step_bit = r_b[W-1];
        if (r_op == ALU_MUL) begin
            t0 = {r_acc[W:0], 1'b0} + (step_bit ? {2'b00, r_a} : '0);
        end else begin
            t0 = {r_acc[W:0], step_bit};
        end
        ge1 = (t0 >= {2'b00, r_m});
        t1  = ge1 ? (t0 - {2'b00, r_m}) : t0;
        // shift-add can reach almost 3m, so a second subtract may be needed
        ge2 = (t1 >= {2'b00, r_m});
        n_acc = ((r_op == ALU_MUL) && ge2) ? (t1 - {2'b00, r_m}) : t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_acc <= '0;
            r_q   <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
            r_op  <= i_req.op;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
            r_q   <= {r_q[W-2:0], ge1};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc[W-1:0];
    assign o_rsp.quo  = r_q;

endmodule

// ----- tb/sv/tb_elgamal_sign_verify_engine_unit.sv -----
`timescale 1ns / 1ps

module tb_elgamal_sign_verify_engine_unit;
    import esv_pkg::*;

    // one request: operation plus all operand fields
    typedef struct {
        logic [0:0]   op;
        logic [W-1:0] hash_value;
        logic [W-1:0] nonce;
        logic [W-1:0] check_first;
        logic [W-1:0] check_second;
    } t_sig_request;

    // one result as the block presents it
    typedef struct {
        logic [W-1:0] sign_first;
        logic [W-1:0] sign_second;
        logic         valid_res;
        logic         nonce_bad;
    } t_sig_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [0:0]   i_op;
    logic [W-1:0] i_hash_value;
    logic [W-1:0] i_nonce;
    logic [W-1:0] i_check_first;
    logic [W-1:0] i_check_second;
    logic         o_valid;
    logic         i_stall;
    logic [W-1:0] o_sign_first;
    logic [W-1:0] o_sign_second;
    logic         o_valid_res;
    logic         o_nonce_bad;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [W-1:0] i_cfg_data;

    // shadow copy of the key registers, mirrors reset defaults
    logic [W-1:0] key_modulus;
    logic [W-1:0] key_generator;
    logic [W-1:0] key_public;
    logic [W-1:0] key_private;

    // signatures still owed by the block, oldest first
    t_sig_result  pending_signatures[$];

    int           mismatch_count;
    int           orphan_count;
    int           result_count;
    int           sign_count;
    int           verify_count;
    int           refused_count;
    int           accepted_count;
    int           hold_cycles;     // long receiver hold-off, counted down below
    bit           stall_enable;    // random receiver stalls on/off

    elgamal_sign_verify_engine_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_hash_value   (i_hash_value),
        .i_nonce        (i_nonce),
        .i_check_first  (i_check_first),
        .i_check_second (i_check_second),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sign_first   (o_sign_first),
        .o_sign_second  (o_sign_second),
        .o_valid_res    (o_valid_res),
        .o_nonce_bad    (o_nonce_bad),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // modular arithmetic at double width
    // ------------------------------------------------------------------
    function automatic logic [63:0] widen(logic [W-1:0] v);
        return {32'd0, v};
    endfunction

    function automatic logic [63:0] mod_mult(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a * b) % m;
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] ex,
                                              logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1 % m;
        sq  = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = mod_mult(acc, sq, m);
            sq = mod_mult(sq, sq, m);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] common_divisor(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // extended euclid; negative coefficient folded back into 0..n-1
    function automatic logic [63:0] mod_inverse(logic [63:0] x, logic [63:0] n);
        longint r0;
        longint r1;
        longint c0;
        longint c1;
        longint q;
        longint rt;
        longint ct;
        r0 = longint'(n);
        r1 = longint'(x % n);
        c0 = 0;
        c1 = 1;
        while (r1 != 0) begin
            q  = r0 / r1;
            rt = r0 - q * r1;
            ct = c0 - q * c1;
            r0 = r1;
            r1 = rt;
            c0 = c1;
            c1 = ct;
        end
        if (c0 < 0) c0 = c0 + longint'(n);
        return 64'(c0) % n;
    endfunction

    // expected signature or verdict for one request under current keys
    function automatic t_sig_result compute_signature(t_sig_request rq);
        t_sig_result rs;
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] s1;
        logic [63:0] s2;
        logic [63:0] hm;
        logic [63:0] t;
        logic [63:0] diff;
        logic [63:0] lhs;
        logic [63:0] rhs;
        rs = '{default: '0};
        p  = widen(key_modulus);
        if (rq.op == OP_SIGN) begin
            if (p < 3) begin
                rs.nonce_bad = 1'b1;
                return rs;
            end
            n = p - 1;
            if (rq.nonce == 0 || widen(rq.nonce) >= n
                || common_divisor(widen(rq.nonce), n) != 1) begin
                rs.nonce_bad = 1'b1;
                return rs;
            end
            s1   = mod_power(widen(key_generator), widen(rq.nonce), p);
            hm   = widen(rq.hash_value) % n;
            t    = mod_mult(widen(key_private) % n, s1 % n, n);
            diff = (hm >= t) ? hm - t : hm + n - t;
            s2   = mod_mult(diff, mod_inverse(widen(rq.nonce), n), n);
            rs.sign_first  = s1[W-1:0];
            rs.sign_second = s2[W-1:0];
        end else begin
            if (p < 3) return rs;
            lhs = mod_power(widen(key_generator), widen(rq.hash_value), p);
            rhs = mod_mult(mod_power(widen(key_public), widen(rq.check_first), p),
                           mod_power(widen(rq.check_first), widen(rq.check_second), p), p);
            rs.valid_res = (lhs == rhs);
        end
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls, long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int burst;
        burst   = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                i_stall <= 1'b1;
            end else if (!stall_enable) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst = burst - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                burst = $urandom_range(20, 120);   // occasional long stall
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // result checker: compare every taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_sig_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (pending_signatures.size() == 0) begin
                orphan_count <= orphan_count + 1;
                if (mismatch_count + orphan_count < 10)
                    $display("unexpected result at %0t", $realtime);
            end else begin
                want = pending_signatures.pop_front();
                if (o_sign_first !== want.sign_first || o_sign_second !== want.sign_second
                    || o_valid_res !== want.valid_res || o_nonce_bad !== want.nonce_bad) begin
                    if (mismatch_count < 10)
                        $display({"mismatch: exp s1=%h s2=%h ok=%b bad=%b",
                                  " got s1=%h s2=%h ok=%b bad=%b"},
                                 want.sign_first, want.sign_second, want.valid_res,
                                 want.nonce_bad, o_sign_first, o_sign_second,
                                 o_valid_res, o_nonce_bad);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------
    // offer one request, wait for it to be taken, then an optional gap
    task automatic send_request(t_sig_request rq, output t_sig_result predicted);
        int gap;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_op           <= rq.op;
        i_hash_value   <= rq.hash_value;
        i_nonce        <= rq.nonce;
        i_check_first  <= rq.check_first;
        i_check_second <= rq.check_second;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = compute_signature(rq);
        pending_signatures.push_back(predicted);
        if (rq.op == OP_SIGN) sign_count++;
        else verify_count++;
        if (predicted.nonce_bad) refused_count++;
        if (predicted.valid_res) accepted_count++;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // sender pause: nothing new until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_signatures.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            REG_MODULUS:     key_modulus   = value;
            REG_GENERATOR:   key_generator = value;
            REG_PUBLIC_KEY:  key_public    = value;
            REG_PRIVATE_KEY: key_private   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // load a full key set; public key derived from generator and secret
    task automatic load_keys(logic [W-1:0] p, logic [W-1:0] g, logic [W-1:0] d);
        logic [63:0] pub;
        pub = mod_power(widen(g), widen(d), widen(p));
        wait_drained();
        write_register(REG_MODULUS, p);
        write_register(REG_GENERATOR, g);
        write_register(REG_PRIVATE_KEY, d);
        write_register(REG_PUBLIC_KEY, pub[W-1:0]);
    endtask

    function automatic t_sig_request make_request(logic [0:0] op, logic [W-1:0] h,
                                                  logic [W-1:0] r, logic [W-1:0] c1,
                                                  logic [W-1:0] c2);
        t_sig_request rq;
        rq.op = op;
        rq.hash_value = h;
        rq.nonce = r;
        rq.check_first = c1;
        rq.check_second = c2;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // default keys after reset: p = 3, so only nonce 1 is usable
    task automatic test_reset_keys();
        t_sig_result got;
        send_request(make_request(OP_SIGN, 32'd5, 32'd1, '0, '0), got);
        send_request(make_request(OP_SIGN, 32'd5, 32'd0, '0, '0), got);
        send_request(make_request(OP_SIGN, 32'd5, 32'd2, '0, '0), got);
        send_request(make_request(OP_VERIFY, 32'd1, '1, '1, '1), got);
    endtask

    // extremes of every field with the largest 32-bit prime
    task automatic test_directed_extremes();
        t_sig_result got;
        t_sig_result sig;
        load_keys(32'hFFFF_FFFB, 32'd2, '1);
        send_request(make_request(OP_SIGN, 32'd0, 32'd1, '0, '0), sig);
        send_request(make_request(OP_VERIFY, 32'd0, '0, sig.sign_first, sig.sign_second), got);
        send_request(make_request(OP_SIGN, '1, 32'hFFFF_FFF9, '0, '0), sig);
        send_request(make_request(OP_VERIFY, '1, '0, sig.sign_first, sig.sign_second), got);
        // corrupted second part must be rejected
        send_request(make_request(OP_VERIFY, '1, '0, sig.sign_first, sig.sign_second ^ 32'd1),
                     got);
        // refused nonces: p-1, all ones, and one sharing the factor 2
        send_request(make_request(OP_SIGN, 32'h1234_5678, 32'hFFFF_FFFA, '0, '0), got);
        send_request(make_request(OP_SIGN, 32'h1234_5678, '1, '0, '0), got);
        send_request(make_request(OP_SIGN, 32'h1234_5678, 32'd1000, '0, '0), got);
        // zero to the power zero counts as one
        send_request(make_request(OP_VERIFY, 32'd0, '0, 32'd0, 32'd0), got);
        send_request(make_request(OP_VERIFY, '1, '1, '1, '1), got);
        // generator and check fields wider than the modulus
        load_keys(32'hFFFF_FFFB, '1, 32'd1);
        send_request(make_request(OP_SIGN, 32'hDEAD_BEEF, 32'd3, '0, '0), sig);
        send_request(make_request(OP_VERIFY, 32'hDEAD_BEEF, '0, sig.sign_first,
                                  sig.sign_second), got);
        send_request(make_request(OP_VERIFY, 32'h8000_0000, '0, 32'hFFFF_FFFC, '1), got);
    endtask

    // mostly sign-then-verify chains, some broken signatures and plain noise
    task automatic run_random_items(int count);
        t_sig_result sig;
        t_sig_result got;
        logic [W-1:0] h;
        logic [W-1:0] r;
        logic [W-1:0] top;
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            h    = $urandom();
            top  = (key_modulus > 3) ? key_modulus - 2 : 32'd1;
            if (kind < 6) begin
                r = $urandom_range(1, top) | 32'd1;
                if (r > top) r = top;
                send_request(make_request(OP_SIGN, h, r, $urandom(), $urandom()), sig);
                if (!sig.nonce_bad) begin
                    if (kind == 0)
                        sig.sign_first = sig.sign_first ^ (32'd1 << $urandom_range(0, 31));
                    else if (kind == 1)
                        h = h ^ (32'd1 << $urandom_range(0, 31));
                    send_request(make_request(OP_VERIFY, h, $urandom(), sig.sign_first,
                                              sig.sign_second), got);
                end
            end else if (kind < 8) begin
                send_request(make_request(OP_SIGN, h, $urandom(), $urandom(), $urandom()), got);
            end else begin
                send_request(make_request(OP_VERIFY, h, $urandom(), $urandom(), $urandom()),
                             got);
            end
        end
    endtask

    // several key sets, including small, non-prime and all-ones extremes
    task automatic test_random_key_sets();
        load_keys(32'hFFFF_FFFB, 32'd2, $urandom());
        run_random_items(14);
        load_keys(32'h7FFF_FFFF, 32'd7, $urandom());
        run_random_items(14);
        stall_enable = 1'b0;   // a stretch with no receiver stalls
        load_keys(32'd1_000_003, 32'd2, '1);
        run_random_items(12);
        stall_enable = 1'b1;
        load_keys(32'd3, 32'd2, 32'd1);
        run_random_items(6);
        load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001);
        run_random_items(8);
        load_keys(32'd251, 32'd6, 32'd97);
        run_random_items(10);
    endtask

    // receiver holds off long while requests keep coming: input must stall
    task automatic test_receiver_hold();
        t_sig_result got;
        load_keys(32'hFFFF_FFFB, 32'd5, 32'h0BAD_F00D);
        hold_cycles = 20000;
        for (int k = 0; k < 3; k++)
            send_request(make_request(OP_SIGN, $urandom(), 32'd7 + 32'd2 * k, '0, '0), got);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_SIGN;
        i_hash_value   = '0;
        i_nonce        = '0;
        i_check_first  = '0;
        i_check_second = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_MODULUS;
        i_cfg_data     = '0;
        key_modulus    = 32'd3;
        key_generator  = 32'd2;
        key_public     = 32'd1;
        key_private    = 32'd1;
        mismatch_count = 0;
        orphan_count   = 0;
        result_count   = 0;
        sign_count     = 0;
        verify_count   = 0;
        refused_count  = 0;
        accepted_count = 0;
        hold_cycles    = 0;
        stall_enable   = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_keys();
        test_directed_extremes();
        test_random_key_sets();
        test_receiver_hold();

        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("covered %0d sign and %0d verify requests over 10 key sets", sign_count,
                 verify_count);
        $display("%0d nonces refused, %0d signatures accepted, %0d results checked",
                 refused_count, accepted_count, result_count);
        if (mismatch_count == 0 && orphan_count == 0 && pending_signatures.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d unexpected results", mismatch_count, orphan_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #200_000_000;
        $display("timeout with %0d results outstanding", pending_signatures.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
